/* src/cau_pkg.sv */
// cau_pkg: types, widths, commands and helper functions of the complex alu
// depends on nothing; used by every module under src
package cau_pkg;

   localparam int DW     = 16;           // operand and result width
   localparam int FB     = 8;            // fraction bits
   localparam int PW     = 2 * DW;       // product width
   localparam int MW     = 2 * DW + 2;   // magnitude width handed to saturation
   localparam int QW     = DW + 1;       // quotient bits produced by the divider cells
   localparam int XW     = 3 * DW + FB + 1; // divider remainder width
   localparam int SW     = 2 * DW + 1;   // square root remainder width
   localparam int CW     = DW + 3;       // cordic x and y width
   localparam int AB     = 20;           // angle fraction bits
   localparam int NIT    = 20;           // cordic iterations
   localparam int ZW     = 24;           // cordic angle width
   localparam int NCELL  = (QW > NIT) ? ((QW > DW) ? QW : DW) : ((NIT > DW) ? NIT : DW);
   localparam logic signed [ZW-1:0] HALF_PI = ZW'(1647099);

   typedef enum logic [2:0] {
      CMD_ADD  = 3'd0,
      CMD_SUB  = 3'd1,
      CMD_MUL  = 3'd2,
      CMD_DIV  = 3'd3,
      CMD_MOD  = 3'd4,
      CMD_ARG  = 3'd5,
      CMD_CONJ = 3'd6,
      CMD_EQ   = 3'd7
   } cmd_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   typedef struct packed {
      cmd_type                cmd;
      logic signed [DW-1:0]   a_re;
      logic signed [DW-1:0]   a_im;
      logic signed [DW-1:0]   b_re;
      logic signed [DW-1:0]   b_im;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0]   res_re;
      logic signed [DW-1:0]   res_im;
      logic                   is_equal;
      logic [1:0]             status;
   } rsp_type;

   typedef struct packed {
      logic [DW-1:0] val;
      logic          sat;
   } sat_type;

   // state handed from cell to cell
   typedef struct packed {
      cmd_type                cmd;
      rsp_type                pre;      // finished word for add, sub, mul, conj, eq
      logic                   dz;
      logic [PW-1:0]          den;
      logic                   neg_re;
      logic                   neg_im;
      logic [XW-1:0]          rem_re;
      logic [XW-1:0]          rem_im;
      logic [QW-1:0]          q_re;
      logic [QW-1:0]          q_im;
      logic [SW-1:0]          srem;
      logic [DW-1:0]          root;
      logic signed [CW-1:0]   cx;
      logic signed [CW-1:0]   cy;
      logic signed [ZW-1:0]   cz;
      logic                   re_zero;
      logic                   im_pos;
      logic                   im_neg;
   } cell_type;

   // atan(2^-i) in q.20
   function automatic logic signed [ZW-1:0] atan_q(input int i);
      logic signed [ZW-1:0] r;
      case (i)
         0:  r = ZW'(823550);
         1:  r = ZW'(486170);
         2:  r = ZW'(256879);
         3:  r = ZW'(130396);
         4:  r = ZW'(65451);
         5:  r = ZW'(32757);
         6:  r = ZW'(16383);
         7:  r = ZW'(8192);
         8:  r = ZW'(4096);
         9:  r = ZW'(2048);
         10: r = ZW'(1024);
         11: r = ZW'(512);
         12: r = ZW'(256);
         13: r = ZW'(128);
         14: r = ZW'(64);
         15: r = ZW'(32);
         16: r = ZW'(16);
         17: r = ZW'(8);
         18: r = ZW'(4);
         19: r = ZW'(2);
         default: r = '0;
      endcase
      return r;
   endfunction

   // sign and magnitude to a saturated two's complement word
   function automatic sat_type sat_pack(input logic neg, input logic [MW-1:0] mag);
      sat_type       r;
      logic [MW-1:0] half;
      logic [MW-1:0] m;
      half  = MW'(1) << (DW - 1);
      m     = mag;
      r.sat = 1'b0;
      if (neg) begin
         if (m > half) begin
            m     = half;
            r.sat = 1'b1;
         end
         r.val = DW'(-m);
      end else begin
         if (m > half - MW'(1)) begin
            m     = half - MW'(1);
            r.sat = 1'b1;
         end
         r.val = DW'(m);
      end
      return r;
   endfunction

   function automatic sat_type sat_s(input logic signed [MW-1:0] v);
      logic [MW-1:0] m;
      m = v[MW-1] ? MW'(-v) : MW'(v);
      return sat_pack(v[MW-1], m);
   endfunction

endpackage

/* src/cau_prep.sv */
// cau_prep: two front stages, products then sums, simple commands finished here
// depends on cau_pkg
module cau_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  cau_pkg::req_type  in_req,
   output logic              out_vld,
   output cau_pkg::cell_type out_cell
);

   localparam int DW   = cau_pkg::DW;
   localparam int PW   = cau_pkg::PW;
   localparam int MW   = cau_pkg::MW;
   localparam int CW_L = cau_pkg::CW;

   logic                  vld1_ff;
   cau_pkg::req_type      req1_ff;
   logic signed [PW-1:0]  p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [PW-1:0]  p_aa_ff, p_ai_ff, p_bb_ff, p_bi_ff;
   logic                  vld2_ff;
   cau_pkg::cell_type     cell_ff;
   cau_pkg::cell_type     cell_in;

   logic signed [PW-1:0]  ar, ai, br, bi;
   assign ar = PW'(in_req.a_re);
   assign ai = PW'(in_req.a_im);
   assign br = PW'(in_req.b_re);
   assign bi = PW'(in_req.b_im);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
      end
      if (adv) begin
         req1_ff <= in_req;
         p_rr_ff <= ar * br;
         p_ii_ff <= ai * bi;
         p_ri_ff <= ar * bi;
         p_ir_ff <= ai * br;
         p_aa_ff <= ar * ar;
         p_ai_ff <= ai * ai;
         p_bb_ff <= br * br;
         p_bi_ff <= bi * bi;
         cell_ff <= cell_in;
      end
   end

   always_comb begin
      logic signed [PW:0]   s_mul_re, s_mul_im, n_re, n_im;
      logic [PW:0]          m_mul_re, m_mul_im, m_re, m_im;
      logic signed [DW:0]   e_re, e_im;
      cau_pkg::sat_type     sre, sim;
      logic signed [CW_L-1:0] xr, xi;

      s_mul_re = (PW+1)'(p_rr_ff) - (PW+1)'(p_ii_ff);
      s_mul_im = (PW+1)'(p_ri_ff) + (PW+1)'(p_ir_ff);
      n_re     = (PW+1)'(p_rr_ff) + (PW+1)'(p_ii_ff);
      n_im     = (PW+1)'(p_ir_ff) - (PW+1)'(p_ri_ff);
      m_mul_re = s_mul_re[PW] ? (PW+1)'(-s_mul_re) : (PW+1)'(s_mul_re);
      m_mul_im = s_mul_im[PW] ? (PW+1)'(-s_mul_im) : (PW+1)'(s_mul_im);
      m_re     = n_re[PW] ? (PW+1)'(-n_re) : (PW+1)'(n_re);
      m_im     = n_im[PW] ? (PW+1)'(-n_im) : (PW+1)'(n_im);

      cell_in = '0;
      cell_in.cmd = req1_ff.cmd;

      unique case (req1_ff.cmd)
         cau_pkg::CMD_ADD: begin
            e_re = (DW+1)'(req1_ff.a_re) + (DW+1)'(req1_ff.b_re);
            e_im = (DW+1)'(req1_ff.a_im) + (DW+1)'(req1_ff.b_im);
            sre  = cau_pkg::sat_s(MW'(e_re));
            sim  = cau_pkg::sat_s(MW'(e_im));
         end
         cau_pkg::CMD_SUB: begin
            e_re = (DW+1)'(req1_ff.a_re) - (DW+1)'(req1_ff.b_re);
            e_im = (DW+1)'(req1_ff.a_im) - (DW+1)'(req1_ff.b_im);
            sre  = cau_pkg::sat_s(MW'(e_re));
            sim  = cau_pkg::sat_s(MW'(e_im));
         end
         cau_pkg::CMD_MUL: begin
            e_re = '0;
            e_im = '0;
            // truncate toward zero on the magnitude
            sre  = cau_pkg::sat_pack(s_mul_re[PW], MW'(m_mul_re >> cau_pkg::FB));
            sim  = cau_pkg::sat_pack(s_mul_im[PW], MW'(m_mul_im >> cau_pkg::FB));
         end
         cau_pkg::CMD_CONJ: begin
            e_re = (DW+1)'(req1_ff.a_re);
            e_im = -((DW+1)'(req1_ff.a_im));
            sre  = cau_pkg::sat_s(MW'(e_re));
            sim  = cau_pkg::sat_s(MW'(e_im));
         end
         default: begin
            e_re = '0;
            e_im = '0;
            sre  = '0;
            sim  = '0;
         end
      endcase

      cell_in.pre.res_re   = sre.val;
      cell_in.pre.res_im   = sim.val;
      cell_in.pre.is_equal = (req1_ff.cmd == cau_pkg::CMD_EQ) &&
                             (req1_ff.a_re == req1_ff.b_re) &&
                             (req1_ff.a_im == req1_ff.b_im);
      cell_in.pre.status   = (sre.sat | sim.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;

      // divider start
      cell_in.den    = PW'($unsigned(p_bb_ff)) + PW'($unsigned(p_bi_ff));
      cell_in.dz     = (req1_ff.b_re == '0) && (req1_ff.b_im == '0);
      cell_in.neg_re = n_re[PW] && (m_re != '0);
      cell_in.neg_im = n_im[PW] && (m_im != '0);
      cell_in.rem_re = cau_pkg::XW'(m_re) << cau_pkg::FB;
      cell_in.rem_im = cau_pkg::XW'(m_im) << cau_pkg::FB;

      // square root start
      cell_in.srem = cau_pkg::SW'(PW'($unsigned(p_aa_ff)) + PW'($unsigned(p_ai_ff)));

      // cordic start, folded into the right half plane
      xr = CW_L'(req1_ff.a_re);
      xi = CW_L'(req1_ff.a_im);
      cell_in.cx      = req1_ff.a_re[DW-1] ? -xr : xr;
      cell_in.cy      = req1_ff.a_re[DW-1] ? -xi : xi;
      cell_in.re_zero = (req1_ff.a_re == '0);
      cell_in.im_pos  = !req1_ff.a_im[DW-1] && (req1_ff.a_im != '0);
      cell_in.im_neg  = req1_ff.a_im[DW-1];
   end

   assign out_vld  = vld2_ff;
   assign out_cell = cell_ff;

endmodule

/* src/cau_cell.sv */
// cau_cell: one step of divider, square root and cordic, registered
// depends on cau_pkg
module cau_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  cau_pkg::cell_type in_cell,
   output logic              out_vld,
   output cau_pkg::cell_type out_cell
);

   localparam int QW = cau_pkg::QW;
   localparam int DW = cau_pkg::DW;
   localparam int XW = cau_pkg::XW;
   localparam int SW = cau_pkg::SW;
   localparam int DJ = (STEP < QW) ? QW - 1 - STEP : 0;
   localparam int SJ = (STEP < DW) ? DW - 1 - STEP : 0;
   localparam logic signed [cau_pkg::ZW-1:0] ATN = cau_pkg::atan_q(STEP);

   logic              vld_ff;
   cau_pkg::cell_type cell_ff;
   cau_pkg::cell_type cell_in;

   always_comb begin
      logic [XW-1:0]             dsh;
      logic [SW-1:0]             trial;
      logic signed [cau_pkg::CW-1:0] dx, dy;

      cell_in = in_cell;

      // restoring division, one quotient bit for each part
      dsh = XW'(in_cell.den) << DJ;
      if (STEP < QW) begin
         if (in_cell.rem_re >= dsh) begin
            cell_in.rem_re    = in_cell.rem_re - dsh;
            cell_in.q_re[DJ]  = 1'b1;
         end
         if (in_cell.rem_im >= dsh) begin
            cell_in.rem_im    = in_cell.rem_im - dsh;
            cell_in.q_im[DJ]  = 1'b1;
         end
      end

      // square root, one root bit
      trial = (SW'(in_cell.root) << (SJ + 1)) | (SW'(1) << (2 * SJ));
      if (STEP < DW) begin
         if (in_cell.srem >= trial) begin
            cell_in.srem      = in_cell.srem - trial;
            cell_in.root[SJ]  = 1'b1;
         end
      end

      // vectoring cordic, one rotation
      dx = in_cell.cy >>> STEP;
      dy = in_cell.cx >>> STEP;
      if (STEP < cau_pkg::NIT) begin
         if (!in_cell.cy[cau_pkg::CW-1]) begin
            cell_in.cx = in_cell.cx + dx;
            cell_in.cy = in_cell.cy - dy;
            cell_in.cz = in_cell.cz + ATN;
         end else begin
            cell_in.cx = in_cell.cx - dx;
            cell_in.cy = in_cell.cy + dy;
            cell_in.cz = in_cell.cz - ATN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_vld;
      end
      if (adv) begin
         cell_ff <= cell_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_cell = cell_ff;

endmodule

/* src/cau_final.sv */
// cau_final: result selection, rounding, saturation and the output register
// depends on cau_pkg
module cau_final (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  cau_pkg::cell_type in_cell,
   output logic              out_vld,
   output cau_pkg::rsp_type  out_rsp
);

   localparam int MW = cau_pkg::MW;
   localparam int ZW = cau_pkg::ZW;

   logic             vld_ff;
   cau_pkg::rsp_type rsp_ff;
   cau_pkg::rsp_type rsp_in;

   always_comb begin
      logic [MW-1:0]          big, mre, mim;
      logic signed [ZW-1:0]   z, zr;
      cau_pkg::sat_type       sre, sim;

      big = MW'(1) << cau_pkg::DW;
      // a remainder still at or above the divisor means the quotient overflowed
      mre = (in_cell.rem_re >= cau_pkg::XW'(in_cell.den)) ? big : MW'(in_cell.q_re);
      mim = (in_cell.rem_im >= cau_pkg::XW'(in_cell.den)) ? big : MW'(in_cell.q_im);

      if (in_cell.re_zero) begin
         z = in_cell.im_pos ? cau_pkg::HALF_PI :
             (in_cell.im_neg ? -cau_pkg::HALF_PI : '0);
      end else begin
         z = in_cell.cz;
      end
      zr = (z + (ZW'(1) << (cau_pkg::AB - cau_pkg::FB - 1))) >>> (cau_pkg::AB - cau_pkg::FB);

      rsp_in = '0;
      unique case (in_cell.cmd)
         cau_pkg::CMD_DIV: begin
            sre = cau_pkg::sat_pack(in_cell.neg_re, mre);
            sim = cau_pkg::sat_pack(in_cell.neg_im, mim);
            if (in_cell.dz) begin
               rsp_in.status = cau_pkg::ST_DIV0;
            end else begin
               rsp_in.res_re = sre.val;
               rsp_in.res_im = sim.val;
               rsp_in.status = (sre.sat | sim.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
         end
         cau_pkg::CMD_MOD: begin
            sre = cau_pkg::sat_pack(1'b0, MW'(in_cell.root));
            sim = '0;
            rsp_in.res_re = sre.val;
            rsp_in.status = sre.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
         end
         cau_pkg::CMD_ARG: begin
            sre = cau_pkg::sat_s(MW'(zr));
            sim = '0;
            rsp_in.res_re = sre.val;
            rsp_in.status = sre.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
         end
         default: begin
            sre = '0;
            sim = '0;
            rsp_in = in_cell.pre;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_vld;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_vld = vld_ff;
   assign out_rsp = rsp_ff;

endmodule

/* src/complex_arith_unit.sv */
// complex_arith_unit: pipelined complex alu, q8.8 operands, one word per cycle
// depends on cau_pkg, cau_prep, cau_cell, cau_final
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   req_data (cau_pkg::req_type)
//   rsp       out        rsp_valid/rsp_ready   rsp_data (cau_pkg::rsp_type)
//
// one word enters per cycle while the pipe advances, through the prep stages,
// the cell chain (divider, square root, cordic side by side) and cau_final
// the whole pipe moves together: it holds only while the output word waits
// and rsp_ready is low; empty slots keep moving while the output is free
// synchronous reset clears the valid bits of every stage
module complex_arith_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cau_pkg::rsp_type rsp_data
);

   localparam int NC = cau_pkg::NCELL;

   logic              adv;
   logic              vld   [NC+1];
   cau_pkg::cell_type cells [NC+1];

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   cau_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (req_valid),
      .in_req   (req_data),
      .out_vld  (vld[0]),
      .out_cell (cells[0])
   );

   for (genvar k = 0; k < NC; k++) begin : g_cell
      cau_cell #(.STEP(k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_vld   (vld[k]),
         .in_cell  (cells[k]),
         .out_vld  (vld[k+1]),
         .out_cell (cells[k+1])
      );
   end

   cau_final u_final (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (vld[NC]),
      .in_cell (cells[NC]),
      .out_vld (rsp_valid),
      .out_rsp (rsp_data)
   );

endmodule
